// ===== design/lru_pkg.sv =====
// Package for the LRU page replacement block: sizes, payload types and the
// lookup result struct shared by the interfaces, lru_sel and the top level.
// No dependencies.
package lru_pkg;

  // Built frame count and page number width
  localparam int FRAMES     = 16;
  localparam int PAGE_WIDTH = 16;

  // Derived widths
  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = SLOT_W;
  localparam int ACT_W  = 5;
  localparam int CNT_W  = 32;

  typedef logic [PAGE_WIDTH-1:0] page_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef logic [FRAMES-1:0][PAGE_WIDTH-1:0] page_arr_t;
  typedef logic [FRAMES-1:0][RANK_W-1:0]     rank_arr_t;

  // Active frame count after reset
  localparam act_t ACT_RESET = act_t'(16);

  // Outcome of one lookup against the frame table
  typedef struct packed {
    logic  hit;    // page resident in an active frame
    logic  fill;   // miss, an empty active frame takes the page
    logic  evict;  // miss, the least recent active frame is replaced
    slot_t slot;   // frame that holds the page afterwards
  } sel_t;

endpackage

// ===== design/lru_if.sv =====
// Request and response channel interfaces for the LRU page replacement block.
// Depends on lru_pkg.
interface lru_req_if import lru_pkg::*;;
  logic  valid;
  logic  ready;
  page_t page;
  logic  last_of_string;

  modport source (output valid, output page, output last_of_string, input ready);
  modport sink   (input valid, input page, input last_of_string, output ready);
endinterface

interface lru_rsp_if import lru_pkg::*;;
  logic  valid;
  logic  ready;
  logic  hit;
  slot_t frame_slot;
  logic  evicted_valid;
  page_t evicted_page;
  cnt_t  fault_count;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

// ===== design/lru_sel.sv =====
// Frame selection for one page request: parallel tag compare, first empty
// frame and least recent frame among the active frames. Depends on lru_pkg.
module lru_sel import lru_pkg::*; (
  input  page_t               page,
  input  page_arr_t           frame_page,
  input  logic [FRAMES-1:0]   frame_valid,
  input  rank_arr_t           rank,
  input  logic [FRAMES-1:0]   active,
  output sel_t                sel
);

  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] empty;
  logic [FRAMES-1:0] oldest;
  slot_t             match_slot;
  slot_t             empty_slot;
  slot_t             oldest_slot;

  // Per-frame compare and empty flags
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = active[i] && frame_valid[i] && (frame_page[i] == page);
      empty[i] = active[i] && !frame_valid[i];
    end
  end

  // Frame i is the victim when it is strictly older than every lower active
  // frame and no younger than every higher one (lowest index wins a tie)
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      oldest[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (active[j] && j < i && !(rank[i] > rank[j])) begin
          oldest[i] = 1'b0;
        end
        if (active[j] && j > i && !(rank[i] >= rank[j])) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  // Lowest set bit of each vector
  always_comb begin
    match_slot  = '0;
    empty_slot  = '0;
    oldest_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_slot = slot_t'(i);
      end
      if (empty[i]) begin
        empty_slot = slot_t'(i);
      end
      if (oldest[i]) begin
        oldest_slot = slot_t'(i);
      end
    end
  end

  // Combine into the lookup outcome
  always_comb begin
    sel.hit   = |match;
    sel.fill  = !(|match) && (|empty);
    sel.evict = !(|match) && !(|empty);
    if (|match) begin
      sel.slot = match_slot;
    end else if (|empty) begin
      sel.slot = empty_slot;
    end else begin
      sel.slot = oldest_slot;
    end
  end

endmodule

// ===== design/lru_page_replacement.sv =====
// Top level of the fully associative LRU page replacement block: request
// register, frame table state, lookup and response register.
// Depends on lru_pkg, lru_req_if, lru_rsp_if and lru_sel.
//
// A request passes from the request register to the response register.
// Throughput: one request per cycle while responses are taken; the whole lookup
// and recency update of a request is combinational between the two registers.
// Reset (rst, synchronous): all frames empty, ranks and fault count zero,
// active frame count 16, both pipeline registers empty.
module lru_page_replacement import lru_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  act_t           cfg_wdata,
  lru_req_if.sink        req,
  lru_rsp_if.source      rsp
);

  // Request stage
  logic  s1_valid;
  page_t s1_page;
  logic  s1_last;
  logic  s1_fire;

  // Frame table and counters
  act_t              active_frames;
  page_arr_t         frame_page;
  logic [FRAMES-1:0] frame_valid;
  rank_arr_t         rank;
  cnt_t              faults;

  logic [FRAMES-1:0] frame_valid_next;
  rank_arr_t         rank_next;
  cnt_t              faults_next;
  cnt_t              faults_inc;
  logic [FRAMES-1:0] active;
  rank_t             slot_rank;
  sel_t              sel;

  // Handshake: the request stage moves when the response register is free
  assign s1_fire   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= ACT_RESET;
    end else if (cfg_we) begin
      active_frames <= cfg_wdata;
    end
  end

  // Active mask: frame 0 always in use, counts above FRAMES clamp naturally
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (int'(active_frames) > i);
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_page <= req.page;
      s1_last <= req.last_of_string;
    end
  end

  lru_sel u_sel (
    .page        (s1_page),
    .frame_page  (frame_page),
    .frame_valid (frame_valid),
    .rank        (rank),
    .active      (active),
    .sel         (sel)
  );

  assign slot_rank  = rank[sel.slot];
  assign faults_inc = (faults == '1) ? faults : faults + cnt_t'(1);

  // Recency update: the chosen frame becomes most recent, younger valid
  // frames age by one (all valid frames on a fill)
  always_comb begin
    frame_valid_next = frame_valid;
    faults_next      = sel.hit ? faults : faults_inc;
    for (int i = 0; i < FRAMES; i++) begin
      if (slot_t'(i) == sel.slot) begin
        rank_next[i] = '0;
      end else if (frame_valid[i] && (sel.fill || rank[i] < slot_rank)) begin
        rank_next[i] = rank[i] + rank_t'(1);
      end else begin
        rank_next[i] = rank[i];
      end
    end
    if (sel.fill) begin
      frame_valid_next[sel.slot] = 1'b1;
    end
    // End of a reference string empties the table
    if (s1_last) begin
      frame_valid_next = '0;
      rank_next        = '0;
      faults_next      = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      rank        <= '0;
      faults      <= '0;
    end else if (s1_fire) begin
      frame_valid <= frame_valid_next;
      rank        <= rank_next;
      faults      <= faults_next;
    end
  end

  // Page tags: written on a miss, no reset
  always_ff @(posedge clk) begin
    if (s1_fire && !sel.hit) begin
      frame_page[sel.slot] <= s1_page;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.hit           <= sel.hit;
      rsp.frame_slot    <= sel.slot;
      rsp.evicted_valid <= sel.evict;
      rsp.evicted_page  <= sel.evict ? frame_page[sel.slot] : '0;
      rsp.fault_count   <= sel.hit ? faults : faults_inc;
    end
  end

  // Checks
  a_slot_active: assert property (@(posedge clk) disable iff (rst)
    s1_fire |-> active[sel.slot])
    else $error("selected frame outside the active range");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot({sel.hit, sel.fill, sel.evict}))
    else $error("lookup outcome not exactly one of hit, fill, evict");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> frame_valid == '0 && faults == '0)
    else $error("end of string did not empty the frame table");

  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_last |=> frame_valid[$past(sel.slot)])
    else $error("frame holding the page is not valid");

  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !sel.hit && !s1_last && faults != '1 |=> faults == $past(faults) + cnt_t'(1))
    else $error("fault counter did not advance on a miss");

endmodule
